### hw/rtl/fqdrr_pkg.sv
// Shared types, constants and codes of the flow queue scheduler.
package fqdrr_pkg;

  localparam int NUM_FLOWS   = 1024;
  localparam int MAX_PACKETS = 4096;
  localparam int FLOW_AW     = $clog2(NUM_FLOWS);
  localparam int DESC_AW     = $clog2(MAX_PACKETS);
  localparam int CNT_W       = DESC_AW + 1;
  localparam int RING_CNT_W  = FLOW_AW + 1;

  localparam logic [10:0] FLOW_COUNT_RESET   = 11'd1024;
  localparam logic [12:0] PACKET_LIMIT_RESET = 13'd4096;
  localparam logic [15:0] QUANTUM_RESET      = 16'd1514;

  localparam logic [1:0] REG_FLOW_COUNT   = 2'd0;
  localparam logic [1:0] REG_PACKET_LIMIT = 2'd1;
  localparam logic [1:0] REG_QUANTUM      = 2'd2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [2:0] KIND_ENQ        = 3'd0;
  localparam logic [2:0] KIND_ENQ_MARKED = 3'd1;
  localparam logic [2:0] KIND_DROP_LIMIT = 3'd2;
  localparam logic [2:0] KIND_DROP_EARLY = 3'd3;
  localparam logic [2:0] KIND_DEQ        = 3'd4;
  localparam logic [2:0] KIND_EMPTY      = 3'd5;

  localparam logic [1:0] MEMB_NONE = 2'd0;
  localparam logic [1:0] MEMB_NEW  = 2'd1;
  localparam logic [1:0] MEMB_OLD  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ENQ_LOOK,
    ST_ENQ_DONE,
    ST_DQ_PICK,
    ST_DQ_RING,
    ST_DQ_FLOW,
    ST_DQ_DESC
  } state_t;

  typedef struct packed {
    logic [10:0] flow_count;
    logic [12:0] packet_limit;
    logic [15:0] quantum;
  } cfg_t;

  typedef struct packed {
    logic [DESC_AW-1:0] first;
    logic [DESC_AW-1:0] last;
    logic [CNT_W-1:0]   packets;
    logic [27:0]        backlog;
    logic signed [17:0] credit;
    logic [1:0]         memb;
  } flow_rec_t;

  localparam int FLOW_REC_W = $bits(flow_rec_t);

  typedef struct packed {
    logic clr;
    logic ready;
    logic enq_look;
    logic enq_done;
    logic dq_pick;
    logic dq_empty;
    logic dq_flow_rd;
    logic dq_rotate;
    logic dq_retire;
    logic dq_desc_rd;
    logic dq_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_valid;
    logic req_deq;
    logic clear_last;
    logic out_free;
    logic any_flow;
    logic credit_le0;
    logic pkts_zero;
  } dp_status_t;

endpackage

### hw/rtl/fqdrr_if.sv
// Request and result channel interfaces of the flow queue scheduler.
interface fqdrr_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] flow_hash;
  logic [15:0] pkt_len;
  logic [15:0] pkt_tag;
  logic [1:0]  pie_verdict;

  modport source(output valid, cmd, flow_hash, pkt_len, pkt_tag, pie_verdict, input ready);
  modport sink(input valid, cmd, flow_hash, pkt_len, pkt_tag, pie_verdict, output ready);
endinterface

interface fqdrr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [9:0]  flow_index;
  logic [15:0] out_tag;
  logic [15:0] out_len;
  logic [27:0] flow_bytes;
  logic        new_flow;

  modport source(output valid, result_kind, flow_index, out_tag, out_len, flow_bytes,
                 new_flow, input ready);
  modport sink(input valid, result_kind, flow_index, out_tag, out_len, flow_bytes,
               new_flow, output ready);
endinterface

### hw/rtl/flow_queue_deficit_round_robin_core.sv
// Top level of the flow queue deficit round robin scheduler.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | cmd, flow_hash, pkt_len, pkt_tag, pie_verdict
//  rsp     | out | valid/ready   | result_kind, flow_index, out_tag, out_len, flow_bytes, new_flow
//  apb     | in  | psel/penable  | paddr, pwdata, prdata (pready tied high)
//
// One item at a time: an enqueue looks up its flow, then writes it back; a dequeue picks a
// flow (or finds both lists empty) and reads it, rotating or retiring flows until one sends
// a descriptor; each rotate or retire is one read-modify-write of the flow table.
// After reset a clearing pass fills the free list and zeroes the flow table; req.ready stays
// low during it. A stalled rsp holds the finished item; work stops only when the next item is
// complete, and the next item is accepted meanwhile.
module flow_queue_deficit_round_robin_core (
  input  logic        clk,
  input  logic        rst,
  fqdrr_req_if.sink   req,
  fqdrr_rsp_if.source rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fqdrr_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  fqdrr_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  fqdrr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .status(status), .cmd(cmd)
  );

  fqdrr_datapath u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .status(status), .req(req), .rsp(rsp)
  );
endmodule

### hw/rtl/fqdrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fqdrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

### hw/rtl/fqdrr_regs.sv
// APB configuration registers of the flow queue scheduler.
module fqdrr_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output fqdrr_pkg::cfg_t    cfg
);
  import fqdrr_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flow_count   <= FLOW_COUNT_RESET;
      cfg.packet_limit <= PACKET_LIMIT_RESET;
      cfg.quantum      <= QUANTUM_RESET;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_FLOW_COUNT:   cfg.flow_count   <= pwdata[10:0];
        REG_PACKET_LIMIT: cfg.packet_limit <= pwdata[12:0];
        REG_QUANTUM:      cfg.quantum      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FLOW_COUNT:   prdata = {21'd0, cfg.flow_count};
      REG_PACKET_LIMIT: prdata = {19'd0, cfg.packet_limit};
      REG_QUANTUM:      prdata = {16'd0, cfg.quantum};
      default:          prdata = 32'd0;
    endcase
  end
endmodule

### hw/rtl/fqdrr_ctrl.sv
// Controller state machine sequencing enqueue, dequeue and the clearing pass.
module fqdrr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  fqdrr_pkg::dp_status_t status,
  output fqdrr_pkg::ctrl_cmd_t  cmd
);
  import fqdrr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (status.clear_last) state_next = ST_IDLE;
      ST_IDLE:     if (status.req_valid) state_next = status.req_deq ? ST_DQ_PICK : ST_ENQ_LOOK;
      ST_ENQ_LOOK: state_next = ST_ENQ_DONE;
      ST_ENQ_DONE: if (status.out_free) state_next = ST_IDLE;
      ST_DQ_PICK: begin
        if (status.any_flow) begin
          state_next = ST_DQ_RING;
        end else if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DQ_RING:  state_next = ST_DQ_FLOW;
      ST_DQ_FLOW: begin
        if (status.credit_le0 || status.pkts_zero) begin
          state_next = ST_DQ_PICK;
        end else begin
          state_next = ST_DQ_DESC;
        end
      end
      ST_DQ_DESC:  if (status.out_free) state_next = ST_IDLE;
      default:     state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR:    cmd.clr = 1'b1;
      ST_IDLE:     cmd.ready = 1'b1;
      ST_ENQ_LOOK: cmd.enq_look = 1'b1;
      ST_ENQ_DONE: cmd.enq_done = status.out_free;
      ST_DQ_PICK: begin
        cmd.dq_pick  = status.any_flow;
        cmd.dq_empty = !status.any_flow && status.out_free;
      end
      ST_DQ_RING:  cmd.dq_flow_rd = 1'b1;
      ST_DQ_FLOW: begin
        cmd.dq_rotate  = status.credit_le0;
        cmd.dq_retire  = !status.credit_le0 && status.pkts_zero;
        cmd.dq_desc_rd = !status.credit_le0 && !status.pkts_zero;
      end
      ST_DQ_DESC:  cmd.dq_done = status.out_free;
      default:     cmd = '0;
    endcase
  end
endmodule

### hw/rtl/fqdrr_datapath.sv
// Datapath: flow table, flow rings, descriptor store, free list and result register.
module fqdrr_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  fqdrr_pkg::cfg_t       cfg,
  input  fqdrr_pkg::ctrl_cmd_t  cmd,
  output fqdrr_pkg::dp_status_t status,
  fqdrr_req_if.sink             req,
  fqdrr_rsp_if.source           rsp
);
  import fqdrr_pkg::*;

  logic [31:0]           hash_q;
  logic [15:0]           len_q;
  logic [15:0]           tag_q;
  logic [1:0]            verdict_q;
  logic [FLOW_AW-1:0]    flow_q;
  logic                  from_new;
  logic [DESC_AW-1:0]    clr_cnt;
  logic [CNT_W-1:0]      total;
  logic [DESC_AW-1:0]    free_head;
  logic [DESC_AW-1:0]    free_tail;
  logic [FLOW_AW-1:0]    new_head;
  logic [RING_CNT_W-1:0] new_cnt;
  logic [FLOW_AW-1:0]    old_head;
  logic [RING_CNT_W-1:0] old_cnt;

  logic [10:0]           fc;
  logic [42:0]           prod;
  logic [FLOW_AW-1:0]    hash_flow;
  logic [15:0]           eq;
  logic signed [17:0]    eq_s;
  logic take;

  logic                  flow_we, flow_re;
  logic [FLOW_AW-1:0]    flow_waddr, flow_raddr;
  logic [FLOW_REC_W-1:0] flow_wbits, flow_rbits;
  flow_rec_t             rec, nrec;

  logic                  new_we, old_we;
  logic [FLOW_AW-1:0]    new_waddr, old_waddr, new_rdata, old_rdata, ring_f;
  logic                  link_we, data_we, free_we;
  logic [DESC_AW-1:0]    link_waddr, link_wdata, link_rdata, free_waddr, free_wdata, free_rdata;
  logic [31:0]           data_rdata;

  logic over, early, accept, was_idle;
  logic pop_new, pop_old, push_old;
  logic load;
  logic [2:0]  kind_next;
  logic [27:0] bytes_next;
  logic        nf_next;
  logic [15:0] otag_next, olen_next;

  assign take       = cmd.ready && req.valid;
  assign req.ready  = cmd.ready;
  assign fc         = (cfg.flow_count > 11'(NUM_FLOWS)) ? 11'(NUM_FLOWS) : cfg.flow_count;
  assign prod       = 43'(hash_q) * 43'(fc);
  assign hash_flow  = prod[32 +: FLOW_AW];
  assign eq         = (cfg.quantum == 16'd0) ? 16'd1 : cfg.quantum;
  assign eq_s       = $signed({2'b00, eq});
  assign rec        = flow_rec_t'(flow_rbits);
  assign ring_f     = from_new ? new_rdata : old_rdata;

  assign over     = (total >= cfg.packet_limit) || (total == CNT_W'(MAX_PACKETS));
  assign early    = verdict_q[1];
  assign accept   = !over && !early;
  assign was_idle = (rec.memb == MEMB_NONE);

  assign status.req_valid  = req.valid;
  assign status.req_deq    = (req.cmd == CMD_DEQ);
  assign status.clear_last = &clr_cnt;
  assign status.out_free   = !rsp.valid || rsp.ready;
  assign status.any_flow   = (new_cnt != '0) || (old_cnt != '0);
  assign status.credit_le0 = rec.credit[17] || (rec.credit == '0);
  assign status.pkts_zero  = (rec.packets == '0);

  always_comb begin
    nrec     = rec;
    pop_new  = 1'b0;
    pop_old  = 1'b0;
    push_old = 1'b0;
    if (cmd.enq_done) begin
      if (rec.packets == '0) begin
        nrec.first = free_rdata;
      end
      nrec.last = free_rdata;
      if (was_idle) begin
        nrec.memb    = MEMB_NEW;
        nrec.credit  = eq_s;
        nrec.packets = '0;
        nrec.backlog = '0;
      end
      nrec.packets = nrec.packets + 1'b1;
      nrec.backlog = nrec.backlog + 28'(len_q);
    end else if (cmd.dq_rotate) begin
      nrec.credit = rec.credit + eq_s;
      nrec.memb   = MEMB_OLD;
      pop_new     = from_new;
      pop_old     = !from_new;
      push_old    = 1'b1;
    end else if (cmd.dq_retire) begin
      pop_new  = from_new;
      pop_old  = !from_new;
      push_old = from_new && (old_cnt != '0);
      nrec.memb = push_old ? MEMB_OLD : MEMB_NONE;
    end else if (cmd.dq_done) begin
      nrec.first   = link_rdata;
      nrec.packets = rec.packets - 1'b1;
      nrec.credit  = rec.credit - $signed({2'b00, data_rdata[31:16]});
      nrec.backlog = rec.backlog - 28'(data_rdata[31:16]);
    end
  end

  always_comb begin
    flow_we    = 1'b0;
    flow_waddr = flow_q;
    flow_wbits = FLOW_REC_W'(nrec);
    if (cmd.clr) begin
      flow_we    = (clr_cnt < DESC_AW'(NUM_FLOWS));
      flow_waddr = clr_cnt[FLOW_AW-1:0];
      flow_wbits = '0;
    end else if ((cmd.enq_done && accept) || cmd.dq_rotate || cmd.dq_retire || cmd.dq_done) begin
      flow_we = 1'b1;
    end
    flow_re    = cmd.enq_look || cmd.dq_flow_rd;
    flow_raddr = cmd.dq_flow_rd ? ring_f : hash_flow;
  end

  assign new_we     = cmd.enq_done && accept && was_idle && (new_cnt < RING_CNT_W'(NUM_FLOWS));
  assign new_waddr  = new_head + new_cnt[FLOW_AW-1:0];
  assign old_we     = push_old;
  assign old_waddr  = old_head + old_cnt[FLOW_AW-1:0];

  assign data_we    = cmd.enq_done && accept;
  assign link_we    = cmd.enq_done && accept && (rec.packets != '0);
  assign link_waddr = rec.last;
  assign link_wdata = free_rdata;

  assign free_we    = cmd.clr || cmd.dq_done;
  assign free_waddr = cmd.clr ? clr_cnt : free_tail;
  assign free_wdata = cmd.clr ? clr_cnt : rec.first;

  fqdrr_ram #(.WIDTH(FLOW_REC_W), .DEPTH(NUM_FLOWS)) u_flow_ram (
    .clk(clk), .wr_en(flow_we), .wr_addr(flow_waddr), .wr_data(flow_wbits),
    .rd_en(flow_re), .rd_addr(flow_raddr), .rd_data(flow_rbits)
  );

  fqdrr_ram #(.WIDTH(FLOW_AW), .DEPTH(NUM_FLOWS)) u_new_ring (
    .clk(clk), .wr_en(new_we), .wr_addr(new_waddr), .wr_data(flow_q),
    .rd_en(cmd.dq_pick), .rd_addr(new_head), .rd_data(new_rdata)
  );

  fqdrr_ram #(.WIDTH(FLOW_AW), .DEPTH(NUM_FLOWS)) u_old_ring (
    .clk(clk), .wr_en(old_we), .wr_addr(old_waddr), .wr_data(flow_q),
    .rd_en(cmd.dq_pick), .rd_addr(old_head), .rd_data(old_rdata)
  );

  fqdrr_ram #(.WIDTH(DESC_AW), .DEPTH(MAX_PACKETS)) u_desc_link (
    .clk(clk), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
    .rd_en(cmd.dq_desc_rd), .rd_addr(rec.first), .rd_data(link_rdata)
  );

  fqdrr_ram #(.WIDTH(32), .DEPTH(MAX_PACKETS)) u_desc_data (
    .clk(clk), .wr_en(data_we), .wr_addr(free_rdata), .wr_data({len_q, tag_q}),
    .rd_en(cmd.dq_desc_rd), .rd_addr(rec.first), .rd_data(data_rdata)
  );

  fqdrr_ram #(.WIDTH(DESC_AW), .DEPTH(MAX_PACKETS)) u_free_ring (
    .clk(clk), .wr_en(free_we), .wr_addr(free_waddr), .wr_data(free_wdata),
    .rd_en(cmd.enq_look), .rd_addr(free_head), .rd_data(free_rdata)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      hash_q    <= req.flow_hash;
      len_q     <= req.pkt_len;
      tag_q     <= req.pkt_tag;
      verdict_q <= req.pie_verdict;
    end
    if (cmd.enq_look) begin
      flow_q <= hash_flow;
    end else if (cmd.dq_flow_rd) begin
      flow_q <= ring_f;
    end
    if (cmd.dq_pick) begin
      from_new <= (new_cnt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      total     <= '0;
      free_head <= '0;
      free_tail <= '0;
      new_head  <= '0;
      new_cnt   <= '0;
      old_head  <= '0;
      old_cnt   <= '0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.enq_done && accept) begin
        free_head <= free_head + 1'b1;
        total     <= total + 1'b1;
      end
      if (cmd.dq_done) begin
        free_tail <= free_tail + 1'b1;
        if (total != '0) begin
          total <= total - 1'b1;
        end
      end
      if (new_we) begin
        new_cnt <= new_cnt + 1'b1;
      end else if (pop_new) begin
        new_head <= new_head + 1'b1;
        new_cnt  <= new_cnt - 1'b1;
      end
      if (pop_old) begin
        old_head <= old_head + 1'b1;
      end
      if (push_old && !pop_old) begin
        old_cnt <= old_cnt + 1'b1;
      end else if (pop_old && !push_old) begin
        old_cnt <= old_cnt - 1'b1;
      end
    end
  end

  assign load = cmd.enq_done || cmd.dq_empty || cmd.dq_done;

  always_comb begin
    kind_next  = KIND_EMPTY;
    bytes_next = '0;
    nf_next    = 1'b0;
    otag_next  = '0;
    olen_next  = '0;
    if (cmd.enq_done) begin
      otag_next = tag_q;
      olen_next = len_q;
      if (over) begin
        kind_next  = KIND_DROP_LIMIT;
        bytes_next = rec.backlog;
      end else if (early) begin
        kind_next  = KIND_DROP_EARLY;
        bytes_next = rec.backlog;
      end else begin
        kind_next  = verdict_q[0] ? KIND_ENQ_MARKED : KIND_ENQ;
        bytes_next = nrec.backlog;
        nf_next    = was_idle;
      end
    end else if (cmd.dq_done) begin
      kind_next  = KIND_DEQ;
      bytes_next = nrec.backlog;
      otag_next  = data_rdata[15:0];
      olen_next  = data_rdata[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.result_kind <= kind_next;
      rsp.flow_index  <= cmd.dq_empty ? '0 : flow_q;
      rsp.out_tag     <= otag_next;
      rsp.out_len     <= olen_next;
      rsp.flow_bytes  <= bytes_next;
      rsp.new_flow    <= nf_next;
    end
  end
endmodule

### hw/rtl/fqdrr_checker.sv
// Port-level checker of the flow queue scheduler, bound to the top level.
module fqdrr_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  result_kind,
  input logic [9:0]  flow_index,
  input logic [15:0] out_tag,
  input logic [15:0] out_len,
  input logic [27:0] flow_bytes,
  input logic        new_flow
);
  import fqdrr_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_kind) && $stable(out_tag))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an item is at work");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && result_kind == KIND_EMPTY |->
      flow_index == '0 && out_tag == '0 && out_len == '0 && flow_bytes == '0 && !new_flow)
    else $error("empty result carries data");

  a_new_flow_enq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && new_flow |-> result_kind == KIND_ENQ || result_kind == KIND_ENQ_MARKED)
    else $error("new flow flag on a result that is no enqueue");
endmodule

bind flow_queue_deficit_round_robin_core fqdrr_checker u_fqdrr_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .result_kind(rsp.result_kind), .flow_index(rsp.flow_index),
  .out_tag(rsp.out_tag), .out_len(rsp.out_len),
  .flow_bytes(rsp.flow_bytes), .new_flow(rsp.new_flow)
);
